// ===== hdl/hssm_pkg.sv =====
package hssm_pkg;

    localparam int REV_STEPS     = 4096;
    localparam int REV_W         = 16;
    localparam int DUR_W         = 24;
    localparam int STEP_W        = 21;
    localparam int MIN_W         = 8;
    localparam int PHASE_W       = 3;
    localparam int COIL_W        = 4;
    localparam int SPR_W         = 17;
    localparam int PROD_W        = REV_W + 1 + SPR_W;
    localparam int SHIFT_W       = PROD_W - 8;
    localparam int CNT_W         = $clog2(DUR_W);

    localparam logic [STEP_W-1:0] MAX_POS_STEPS = STEP_W'(1048575);
    localparam logic [STEP_W-1:0] MAX_NEG_STEPS = STEP_W'(1048576);
    localparam logic [MIN_W-1:0]  MIN_RESET     = MIN_W'(1);
    localparam logic [DUR_W-1:0]  DELAY_RESET   = DUR_W'(2);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic exec;
        logic start_div;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic need_div;
        logic out_free;
        logic div_done;
    } t_dp_sts;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        begin
            case (ph)
                3'd0:    pat = 4'h1;
                3'd1:    pat = 4'h3;
                3'd2:    pat = 4'h2;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h4;
                3'd5:    pat = 4'hC;
                3'd6:    pat = 4'h8;
                3'd7:    pat = 4'h9;
                default: pat = 4'h0;
            endcase
            return pat;
        end
    endfunction

endpackage

// ===== hdl/hssm_div.sv =====
module hssm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hssm_pkg::DUR_W-1:0]   i_dividend,
    input  logic [hssm_pkg::STEP_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [hssm_pkg::DUR_W-1:0]   o_quotient
);
    import hssm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_rem;
    logic [DUR_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_dvs;
    logic [STEP_W:0]   w_trial;

    assign w_trial    = {r_rem, r_quo[DUR_W-1]} - {1'b0, r_dvs};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DUR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[STEP_W]) begin
                r_rem <= w_trial[STEP_W-1:0];
                r_quo <= {r_quo[DUR_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[STEP_W-2:0], r_quo[DUR_W-1]};
                r_quo <= {r_quo[DUR_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hdl/hssm_dp.sv =====
module hssm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hssm_pkg::t_dp_ctl                   i_ctl,
    output hssm_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [hssm_pkg::MIN_W-1:0]          i_cfg_data,
    input  logic                                i_cmd,
    input  logic signed [hssm_pkg::REV_W-1:0]   i_revolutions_q8,
    input  logic [hssm_pkg::DUR_W-1:0]          i_duration_ms,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [hssm_pkg::COIL_W-1:0]         o_coil_pattern,
    output logic                                o_coils_energized,
    output logic [hssm_pkg::PHASE_W-1:0]        o_phase,
    output logic signed [hssm_pkg::STEP_W-1:0]  o_steps_left,
    output logic                                o_step_taken,
    output logic                                o_busy_res
);
    import hssm_pkg::*;

    logic [MIN_W-1:0]          r_min;
    logic signed [STEP_W-1:0]  r_rem;
    logic [DUR_W-1:0]          r_sd;
    logic [DUR_W-1:0]          r_dl;
    logic [PHASE_W-1:0]        r_ph;
    logic                      r_en;
    logic                      r_neg;
    logic [STEP_W-1:0]         r_mag;
    logic                      r_out_valid;
    logic [COIL_W-1:0]         r_coil;
    logic                      r_energ;
    logic [PHASE_W-1:0]        r_phase;
    logic signed [STEP_W-1:0]  r_left;
    logic                      r_taken;
    logic                      r_busy;

    logic signed [STEP_W-1:0]  n_rem;
    logic [DUR_W-1:0]          n_sd;
    logic [DUR_W-1:0]          n_dl;
    logic [PHASE_W-1:0]        n_ph;
    logic                      n_en;
    logic                      w_step;

    logic                      w_neg;
    logic [REV_W:0]            w_rmag;
    logic [PROD_W-1:0]         w_prod;
    logic [SHIFT_W-1:0]        w_shift;
    logic [STEP_W-1:0]         w_limit;
    logic [STEP_W-1:0]         w_mag;
    logic                      w_div_done;
    logic [DUR_W-1:0]          w_quo;
    logic [MIN_W-1:0]          w_floor;
    logic [DUR_W-1:0]          w_delay;
    logic signed [STEP_W-1:0]  w_new_rem;
    logic                      w_load;

    assign w_neg   = i_revolutions_q8[REV_W-1];
    assign w_rmag  = w_neg ? ((REV_W+1)'(1 << REV_W) - {1'b0, i_revolutions_q8})
                           : {1'b0, i_revolutions_q8};
    assign w_prod  = PROD_W'(w_rmag) * PROD_W'(REV_STEPS);
    assign w_shift = w_prod[PROD_W-1:8];
    assign w_limit = w_neg ? MAX_NEG_STEPS : MAX_POS_STEPS;
    assign w_mag   = (w_shift > SHIFT_W'(w_limit)) ? w_limit : w_shift[STEP_W-1:0];

    hssm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.start_div),
        .i_dividend (i_duration_ms),
        .i_divisor  (w_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_floor   = (r_min == '0) ? MIN_W'(1) : r_min;
    assign w_delay   = (w_quo < DUR_W'(w_floor)) ? DUR_W'(w_floor) : w_quo;
    assign w_new_rem = r_neg ? (STEP_W'(0) - $signed(r_mag)) : $signed(r_mag);
    assign w_load    = i_ctl.exec || i_ctl.finish;

    assign o_sts.need_div = i_cmd && (w_mag != '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.div_done = w_div_done;

    always_comb begin
        n_rem  = r_rem;
        n_sd   = r_sd;
        n_dl   = r_dl;
        n_ph   = r_ph;
        n_en   = r_en;
        w_step = 1'b0;
        if (i_ctl.exec) begin
            if (i_cmd) begin
                if (i_revolutions_q8 == '0) begin
                    n_rem = '0;
                end
            end else if (r_dl != '0) begin
                n_dl = r_dl - DUR_W'(1);
                if (r_dl == DUR_W'(1)) begin
                    if (r_rem != '0) begin
                        w_step = 1'b1;
                    end else begin
                        n_en = 1'b0;
                    end
                end
            end
        end
        if (i_ctl.finish) begin
            n_sd  = w_delay;
            n_rem = w_new_rem;
            if (r_dl == '0) begin
                w_step = 1'b1;
            end
        end
        if (w_step) begin
            if (n_rem > 0) begin
                n_ph  = n_ph + PHASE_W'(1);
                n_rem = n_rem - STEP_W'(1);
            end else begin
                n_ph  = n_ph - PHASE_W'(1);
                n_rem = n_rem + STEP_W'(1);
            end
            n_en = 1'b1;
            n_dl = n_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_RESET;
            r_rem       <= '0;
            r_sd        <= DELAY_RESET;
            r_dl        <= '0;
            r_ph        <= '0;
            r_en        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            r_rem <= n_rem;
            r_sd  <= n_sd;
            r_dl  <= n_dl;
            r_ph  <= n_ph;
            r_en  <= n_en;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_div) begin
            r_neg <= w_neg;
            r_mag <= w_mag;
        end
        if (w_load) begin
            r_coil  <= n_en ? coil_pattern(n_ph) : '0;
            r_energ <= n_en;
            r_phase <= n_ph;
            r_left  <= n_rem;
            r_taken <= w_step;
            r_busy  <= (n_dl != '0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_coil_pattern    = r_coil;
    assign o_coils_energized = r_energ;
    assign o_phase           = r_phase;
    assign o_steps_left      = r_left;
    assign o_step_taken      = r_taken;
    assign o_busy_res        = r_busy;

endmodule

// ===== hdl/hssm_ctrl.sv =====
module hssm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hssm_pkg::t_dp_sts  i_sts,
    output hssm_pkg::t_dp_ctl  o_ctl
);
    import hssm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_sts.need_div) begin
                        o_ctl.start_div = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        o_ctl.exec = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/half_step_stepper_move_controller_unit.sv =====
// Timing: a tick or a zero-step command gives its registered result in the cycle after
// acceptance; a move command gives its result once the divider has finished.
// Flow: one tick per cycle while the output is not stalled; the input stalls while a
// move runs the bit-serial restoring divider that computes the step delay.
// Reset: synchronous, active low; clears the motion state, sets the delay floor to 1.
module half_step_stepper_move_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hssm_pkg::MIN_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic signed [hssm_pkg::REV_W-1:0]   i_revolutions_q8,
    input  logic [hssm_pkg::DUR_W-1:0]          i_duration_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hssm_pkg::COIL_W-1:0]         o_coil_pattern,
    output logic                                o_coils_energized,
    output logic [hssm_pkg::PHASE_W-1:0]        o_phase,
    output logic signed [hssm_pkg::STEP_W-1:0]  o_steps_left,
    output logic                                o_step_taken,
    output logic                                o_busy_res
);
    import hssm_pkg::*;

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    hssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    hssm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_revolutions_q8  (i_revolutions_q8),
        .i_duration_ms     (i_duration_ms),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_coil_pattern    (o_coil_pattern),
        .o_coils_energized (o_coils_energized),
        .o_phase           (o_phase),
        .o_steps_left      (o_steps_left),
        .o_step_taken      (o_step_taken),
        .o_busy_res        (o_busy_res)
    );

    a_finish_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |-> w_sts.div_done)
        else $error("command finished without a divider result");

    a_stall_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start_div |=> o_in_stall)
        else $error("input taken while the divider runs");

    a_idle_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (o_steps_left == '0))
        else $error("steps remain while no delay runs");

    a_step_energizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_taken) |-> (o_coils_energized && o_busy_res))
        else $error("step taken with coils off or no delay");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic [hssm_pkg::COIL_W-1:0]  coils;
    logic                         energized;
    logic [hssm_pkg::PHASE_W-1:0] phase;
    logic [hssm_pkg::STEP_W-1:0]  steps_left;
    logic                         stepped;
    logic                         busy;
} t_drive_state;

class t_motion_tracker;
    t_drive_state                 drive_due[$];
    int                           mismatches;
    logic [hssm_pkg::MIN_W-1:0]   floor_reg;
    int                           remaining;
    logic [hssm_pkg::DUR_W-1:0]   step_delay;
    logic [hssm_pkg::DUR_W-1:0]   delay_left;
    logic [hssm_pkg::PHASE_W-1:0] cur_phase;
    logic                         energized;
    logic [hssm_pkg::COIL_W-1:0]  coil_seq[8];

    function new();
        mismatches = 0;
        floor_reg  = 8'd1;
        remaining  = 0;
        step_delay = 24'd2;
        delay_left = 24'd0;
        cur_phase  = 3'd0;
        energized  = 1'b0;
        coil_seq   = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    endfunction

    function void set_floor(logic [hssm_pkg::MIN_W-1:0] v);
        floor_reg = v;
    endfunction

    function void step_once();
        if (remaining > 0) begin
            cur_phase = cur_phase + 3'd1;
            remaining = remaining - 1;
        end else begin
            cur_phase = cur_phase - 3'd1;
            remaining = remaining + 1;
        end
        energized  = 1'b1;
        delay_left = step_delay;
    endfunction

    function void note_item(logic cmd, logic signed [hssm_pkg::REV_W-1:0] rev,
                            logic [hssm_pkg::DUR_W-1:0] dur);
        longint       mag;
        longint       lim;
        longint       d;
        logic         stepped;
        t_drive_state st;
        stepped = 1'b0;
        if (cmd) begin
            if (rev == 16'sd0) begin
                remaining = 0;
            end else begin
                mag = (rev < 0) ? -longint'(rev) : longint'(rev);
                mag = (mag * hssm_pkg::REV_STEPS) >>> 8;
                lim = (rev < 0) ? 1048576 : 1048575;
                if (mag > lim)
                    mag = lim;
                if (mag != 0) begin
                    lim = (floor_reg == 8'd0) ? 1 : longint'(floor_reg);
                    d = longint'(dur) / mag;
                    if (d < lim)
                        d = lim;
                    step_delay = d[hssm_pkg::DUR_W-1:0];
                    remaining  = (rev < 0) ? -int'(mag) : int'(mag);
                    if (delay_left == 24'd0) begin
                        step_once();
                        stepped = 1'b1;
                    end
                end
            end
        end else if (delay_left != 24'd0) begin
            delay_left = delay_left - 24'd1;
            if (delay_left == 24'd0) begin
                if (remaining != 0) begin
                    step_once();
                    stepped = 1'b1;
                end else begin
                    energized = 1'b0;
                end
            end
        end
        st.coils      = energized ? coil_seq[cur_phase] : 4'h0;
        st.energized  = energized;
        st.phase      = cur_phase;
        st.steps_left = remaining[hssm_pkg::STEP_W-1:0];
        st.stepped    = stepped;
        st.busy       = (delay_left != 24'd0);
        drive_due.push_back(st);
    endfunction

    function void check_drive(logic [hssm_pkg::COIL_W-1:0] coils, logic en,
                              logic [hssm_pkg::PHASE_W-1:0] ph,
                              logic [hssm_pkg::STEP_W-1:0] left, logic stepped,
                              logic busy);
        t_drive_state got;
        t_drive_state want;
        got = '{coils, en, ph, left, stepped, busy};
        if (drive_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("drive result with nothing expected: coils=%h ph=%0d left=%0d",
                         coils, ph, $signed(left));
            return;
        end
        want = drive_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("drive mismatch exp: coils=%h en=%b ph=%0d left=%0d step=%b busy=%b",
                         want.coils, want.energized, want.phase, $signed(want.steps_left),
                         want.stepped, want.busy);
                $display("               got: coils=%h en=%b ph=%0d left=%0d step=%b busy=%b",
                         got.coils, got.energized, got.phase, $signed(got.steps_left),
                         got.stepped, got.busy);
            end
        end
    endfunction
endclass

module tb;
    import hssm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [MIN_W-1:0]           cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       cmd       = 1'b0;
    logic signed [REV_W-1:0]    rev       = '0;
    logic [DUR_W-1:0]           dur       = '0;
    logic                       out_stall = 1'b0;
    logic                       calm      = 1'b0;
    int                         cycles    = 0;
    int                         stall_run = 0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [COIL_W-1:0]          o_coil_pattern;
    logic                       o_coils_energized;
    logic [PHASE_W-1:0]         o_phase;
    logic signed [STEP_W-1:0]   o_steps_left;
    logic                       o_step_taken;
    logic                       o_busy_res;

    t_motion_tracker tracker;

    half_step_stepper_move_controller_unit DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (cmd),
        .i_revolutions_q8  (rev),
        .i_duration_ms     (dur),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_coil_pattern    (o_coil_pattern),
        .o_coils_energized (o_coils_energized),
        .o_phase           (o_phase),
        .o_steps_left      (o_steps_left),
        .o_step_taken      (o_step_taken),
        .o_busy_res        (o_busy_res)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall)
            tracker.check_drive(o_coil_pattern, o_coils_energized, o_phase, o_steps_left,
                                o_step_taken, o_busy_res);
        if (stall_run > 0) begin
            stall_run = stall_run - 1;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(0, 13);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic c, input logic signed [REV_W-1:0] r,
                             input logic [DUR_W-1:0] d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        rev      <= r;
        dur      <= d;
        do @(posedge clk); while (o_in_stall);
        tracker.note_item(c, r, d);
    endtask

    task automatic write_floor(input logic [MIN_W-1:0] v);
        in_valid <= 1'b0;
        while (tracker.drive_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_floor(v);
    endtask

    task automatic directed_items();
        send_item(1'b0, 16'sd0, 24'd0);
        send_item(1'b1, 16'sd0, 24'd0);
        send_item(1'b1, 16'sd1, 24'd0);
        send_item(1'b0, 16'sd0, 24'd0);
        send_item(1'b0, 16'sd0, 24'd0);
        send_item(1'b1, 16'sh8000, 24'hFFFFFF);
        send_item(1'b1, 16'sh7FFF, 24'hFFFFFF);
        send_item(1'b1, -16'sd1, 24'd48);
        repeat (3) send_item(1'b0, 16'sd0, 24'd0);
        send_item(1'b1, 16'sd0, 24'hFFFFFF);
        repeat (4) send_item(1'b0, 16'shFFFF, 24'hFFFFFF);
        send_item(1'b1, 16'sh0100, 24'd5000);
        send_item(1'b1, 16'sd0, 24'd0);
        repeat (3) send_item(1'b0, 16'sd0, 24'd0);
    endtask

    task automatic random_moves(input int count);
        int         k;
        int         pick;
        int         r;
        longint     steps;
        logic [DUR_W-1:0] d;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) >= 6) begin
                send_item(1'b0, REV_W'($urandom), DUR_W'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    r = 0;
                else if (pick < 70)
                    r = $urandom_range(1, 4);
                else if (pick < 90)
                    r = $signed(REV_W'($urandom));
                else
                    r = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                if (pick >= 12 && pick < 70 && $urandom_range(0, 1) == 1)
                    r = -r;
                steps = (r < 0) ? -r : r;
                steps = (steps * REV_STEPS) >>> 8;
                d = DUR_W'($urandom);
                // keep the per-step delay short so moves run to the end
                if (steps != 0 && $urandom_range(0, 2) != 0)
                    d = DUR_W'($urandom_range(0, 3 * steps));
                else if (steps != 0)
                    while (d / steps > 40) d = d >> 1;
                send_item(1'b1, REV_W'(r), d);
            end
        end
    endtask

    initial begin
        int               p;
        logic [MIN_W-1:0] floors[8];
        tracker = new();
        floors = '{8'd255, 8'd0, 8'd1, 8'd3, 8'd2, 8'd5, 8'd1, 8'd1};
        floors[3] = $urandom_range(2, 9);
        floors[5] = $urandom_range(2, 9);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_floor(8'd1);
        directed_items();
        for (p = 0; p < 8; p++) begin
            write_floor(floors[p]);
            calm = (p == 7);
            random_moves((floors[p] == 8'd255) ? 150 : 235);
        end
        in_valid <= 1'b0;
        while (tracker.drive_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.drive_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
